@@ rtl/core/ubxs_pkg.sv @@
// ----------------------------------------------------------------------------
// ubxs_pkg
// Shared types, codes and constants for the UBX command sender core.
// ----------------------------------------------------------------------------
package ubxs_pkg;

  localparam int unsigned UBXS_QUEUE_DEPTH = 4;
  localparam int unsigned WORD_IDX_W       = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam logic [7:0] SYNC_ONE   = 8'hB5;
  localparam logic [7:0] SYNC_TWO   = 8'h62;
  localparam logic [7:0] ACK_CLASS  = 8'h05;
  localparam logic [7:0] ACK_ID_ACK = 8'h01;
  localparam logic [7:0] ACK_ID_NAK = 8'h00;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD = 2'd1;
  localparam logic [1:0] REQ_RECV    = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  localparam logic [1:0] OUTCOME_ACK     = 2'd0;
  localparam logic [1:0] OUTCOME_NAK     = 2'd1;
  localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

  localparam logic [3:0] MATCH_LAST = 4'd9;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_BYTE,
    JOB_STATUS
  } job_kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       status_valid;
    logic [1:0] outcome;
  } out_word_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        finish;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [1:0]  outcome;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

@@ rtl/core/ubxs_queue.sv @@
// ----------------------------------------------------------------------------
// ubxs_queue
// Small job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module ubxs_queue
  import ubxs_pkg::*;
#(
  parameter int unsigned Depth = UBXS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  job_push_t push,
  input  logic      pop,
  output logic      full,
  output logic      nonempty,
  output job_t      head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == FullCnt);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ubxs_front.sv @@
// ----------------------------------------------------------------------------
// ubxs_front
// Accepts items, keeps command, checksum, reply matcher and timer state,
// and queues one job for every item that causes output words.
// ----------------------------------------------------------------------------
module ubxs_front
  import ubxs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_full,
  output job_push_t   push
);

  phase_t      phase, phase_next;
  logic [7:0]  cmd_class, cmd_class_next;
  logic [7:0]  cmd_ident, cmd_ident_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [3:0]  match_index, match_index_next;
  logic        reply_is_ack, reply_is_ack_next;
  logic [7:0]  reply_class, reply_class_next;
  logic [7:0]  reply_ident, reply_ident_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] ack_timeout_ms;

  logic        acc;
  logic [7:0]  hdr_a1, hdr_a2, hdr_a3, hdr_a4;
  logic [7:0]  hdr_b2, hdr_b3, hdr_b4;
  logic [7:0]  pay_a, pay_b;
  logic [15:0] elapsed_inc;
  logic        timeout_hit;
  logic        reply_hit;
  logic [7:0]  d;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign d        = in_data.data_byte;

  assign hdr_a1 = in_data.msg_class;
  assign hdr_a2 = hdr_a1 + in_data.msg_ident;
  assign hdr_b2 = hdr_a1 + hdr_a2;
  assign hdr_a3 = hdr_a2 + in_data.payload_length[7:0];
  assign hdr_b3 = hdr_b2 + hdr_a3;
  assign hdr_a4 = hdr_a3 + in_data.payload_length[15:8];
  assign hdr_b4 = hdr_b3 + hdr_a4;

  assign pay_a = sum_a + d;
  assign pay_b = sum_b + pay_a;

  assign elapsed_inc = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;
  assign timeout_hit = (elapsed_inc >= ack_timeout_ms);
  assign reply_hit   = (match_index == MATCH_LAST) && (reply_class == cmd_class)
                       && (reply_ident == cmd_ident);

  always_comb begin
    phase_next        = phase;
    cmd_class_next    = cmd_class;
    cmd_ident_next    = cmd_ident;
    bytes_left_next   = bytes_left;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    match_index_next  = match_index;
    reply_is_ack_next = reply_is_ack;
    reply_class_next  = reply_class;
    reply_ident_next  = reply_ident;
    elapsed_ms_next   = elapsed_ms;
    if (acc) begin
      unique case (in_data.req_type)
        REQ_START: begin
          cmd_class_next   = in_data.msg_class;
          cmd_ident_next   = in_data.msg_ident;
          bytes_left_next  = in_data.payload_length;
          sum_a_next       = hdr_a4;
          sum_b_next       = hdr_b4;
          match_index_next = '0;
          elapsed_ms_next  = '0;
          phase_next       = (in_data.payload_length == '0) ? PH_WAIT : PH_SEND;
        end
        REQ_PAYLOAD: begin
          if (phase == PH_SEND) begin
            sum_a_next      = pay_a;
            sum_b_next      = pay_b;
            bytes_left_next = bytes_left - 16'd1;
            if (bytes_left == 16'd1) begin
              phase_next       = PH_WAIT;
              match_index_next = '0;
              elapsed_ms_next  = '0;
            end
          end
        end
        REQ_RECV: begin
          if (phase == PH_WAIT) begin
            case (match_index)
              4'd0: match_index_next = (d == SYNC_ONE) ? 4'd1 : 4'd0;
              4'd1: match_index_next = (d == SYNC_TWO) ? 4'd2 : 4'd0;
              4'd2: match_index_next = (d == ACK_CLASS) ? 4'd3 : 4'd0;
              4'd3: begin
                if (d == ACK_ID_ACK || d == ACK_ID_NAK) begin
                  reply_is_ack_next = (d == ACK_ID_ACK);
                  match_index_next  = 4'd4;
                end else begin
                  match_index_next = 4'd0;
                end
              end
              4'd4, 4'd5, 4'd8: match_index_next = match_index + 4'd1;
              4'd6: begin
                reply_class_next = d;
                match_index_next = 4'd7;
              end
              4'd7: begin
                reply_ident_next = d;
                match_index_next = 4'd8;
              end
              MATCH_LAST: begin
                match_index_next = 4'd0;
                if (reply_hit) begin
                  phase_next = PH_IDLE;
                end
              end
              default: match_index_next = 4'd0;
            endcase
          end
        end
        REQ_TICK: begin
          if (phase == PH_WAIT) begin
            elapsed_ms_next = elapsed_inc;
            if (timeout_hit) begin
              phase_next       = PH_IDLE;
              match_index_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push                    = '0;
    push.job.kind           = JOB_STATUS;
    push.job.msg_class      = in_data.msg_class;
    push.job.msg_ident      = in_data.msg_ident;
    push.job.payload_length = in_data.payload_length;
    push.job.data_byte      = d;
    if (acc) begin
      unique case (in_data.req_type)
        REQ_START: begin
          push.valid      = 1'b1;
          push.job.kind   = JOB_HEADER;
          push.job.finish = (in_data.payload_length == '0);
          push.job.ck_a   = hdr_a4;
          push.job.ck_b   = hdr_b4;
        end
        REQ_PAYLOAD: begin
          push.valid      = (phase == PH_SEND);
          push.job.kind   = JOB_BYTE;
          push.job.finish = (bytes_left == 16'd1);
          push.job.ck_a   = pay_a;
          push.job.ck_b   = pay_b;
        end
        REQ_RECV: begin
          push.valid       = (phase == PH_WAIT) && reply_hit;
          push.job.outcome = reply_is_ack ? OUTCOME_ACK : OUTCOME_NAK;
        end
        REQ_TICK: begin
          push.valid       = (phase == PH_WAIT) && timeout_hit;
          push.job.outcome = OUTCOME_TIMEOUT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      cmd_class      <= '0;
      cmd_ident      <= '0;
      bytes_left     <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      match_index    <= '0;
      reply_is_ack   <= 1'b0;
      reply_class    <= '0;
      reply_ident    <= '0;
      elapsed_ms     <= '0;
      ack_timeout_ms <= TIMEOUT_RESET;
    end else begin
      phase        <= phase_next;
      cmd_class    <= cmd_class_next;
      cmd_ident    <= cmd_ident_next;
      bytes_left   <= bytes_left_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      match_index  <= match_index_next;
      reply_is_ack <= reply_is_ack_next;
      reply_class  <= reply_class_next;
      reply_ident  <= reply_ident_next;
      elapsed_ms   <= elapsed_ms_next;
      if (cfg_we) begin
        ack_timeout_ms <= cfg_wdata;
      end
    end
  end

endmodule

@@ rtl/core/ubxs_back.sv @@
// ----------------------------------------------------------------------------
// ubxs_back
// Expands queued jobs into output words, one word per cycle while out_ready does
// not hold the output, through a registered output stage.
// ----------------------------------------------------------------------------
module ubxs_back
  import ubxs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [WORD_IDX_W-1:0] idx;
  out_word_t             word;
  logic                  load;

  always_comb begin
    word = '0;
    unique case (job.kind)
      JOB_HEADER: begin
        word.tx_valid = 1'b1;
        unique case (idx)
          3'd0: word.tx_byte = SYNC_ONE;
          3'd1: word.tx_byte = SYNC_TWO;
          3'd2: word.tx_byte = job.msg_class;
          3'd3: word.tx_byte = job.msg_ident;
          3'd4: word.tx_byte = job.payload_length[7:0];
          3'd5: word.tx_byte = job.payload_length[15:8];
          3'd6: word.tx_byte = job.ck_a;
          3'd7: word.tx_byte = job.ck_b;
          default: word.tx_byte = job.ck_b;
        endcase
        word.last = job.finish ? (idx == 3'd7) : (idx == 3'd5);
      end
      JOB_BYTE: begin
        word.tx_valid = 1'b1;
        priority case (idx)
          3'd0:    word.tx_byte = job.data_byte;
          3'd1:    word.tx_byte = job.ck_a;
          default: word.tx_byte = job.ck_b;
        endcase
        word.last = job.finish ? (idx == 3'd2) : (idx == 3'd0);
      end
      JOB_STATUS: begin
        word.status_valid = 1'b1;
        word.outcome      = job.outcome;
        word.last         = 1'b1;
      end
      default: word.last = 1'b1;
    endcase
  end

  assign load = job_valid && (!out_valid || out_ready);
  assign pop  = load && word.last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= word.last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_needs_job: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> job_valid)
    else $error("word index advanced with no job at the queue head");

  a_status_word_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status_valid) |-> (!out_data.tx_valid && out_data.last))
    else $error("status word is not a lone final word");

  a_tx_word_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tx_valid) |->
      (!out_data.status_valid && out_data.outcome == OUTCOME_ACK))
    else $error("transmit word carries status fields");
`endif

endmodule

@@ rtl/core/ubx_command_sender_ack_wait_core.sv @@
// ----------------------------------------------------------------------------
// ubx_command_sender_ack_wait_core
// Sends one UBX command frame with Fletcher checksum and waits for ACK/NAK or a timeout.
// ----------------------------------------------------------------------------
// An item is accepted in every cycle in which the job queue has room: the front
// classifies it combinationally and queues a job. The back emits one output word
// per cycle while out_ready allows; a start yields 6 words (8 with an empty
// payload), a payload byte 1 (3 when it is the last one), a matched reply or
// timeout 1, and other items none. Sustained rate is one item per cycle at one
// word per item with no stall; the QueueDepth-entry queue absorbs header bursts.
module ubx_command_sender_ack_wait_core
  import ubxs_pkg::*;
#(
  parameter int unsigned QueueDepth = UBXS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  job_push_t push;
  logic      q_full;
  logic      q_nonempty;
  logic      pop;
  job_t      head;

  ubxs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  ubxs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head)
  );

  ubxs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
